### rtl/core/mmix_pkg.sv
// Shared types, register indexes and mixing coefficients for the motor mixer.
// No dependencies; imported by multirotor_motor_mixer_core.
package mmix_pkg;

  // Width of every command, correction and configuration value
  localparam int CMD_W = 13;
  // Width of the configuration register index
  localparam int REG_IDX_W = 3;
  // Number of motor outputs
  localparam int N_MOTORS = 6;
  // Width of a motor number
  localparam int MOTOR_W = 3;
  // Fraction bits of the Q2.14 coefficients
  localparam int FRAC_W = 14;
  // Width of a mixing coefficient
  localparam int COEF_W = 16;

  // Frame codes
  localparam logic [1:0] FRAME_TRI    = 2'd0;
  localparam logic [1:0] FRAME_QUAD_X = 2'd1;
  localparam logic [1:0] FRAME_HEX_X  = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FRAME_TYPE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_YAW_REVERSE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_THROTTLE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_THROTTLE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STICK_LOW_CHECK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_CENTER     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_LOW_LIMIT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_HIGH_LIMIT = 3'd7;

  // Q2.14 coefficient values
  localparam logic signed [COEF_W-1:0] Q_ONE = 16'sd16384;
  localparam logic signed [COEF_W-1:0] Q_2_3 = 16'sd10923;
  localparam logic signed [COEF_W-1:0] Q_4_3 = 16'sd21845;
  localparam logic signed [COEF_W-1:0] Q_HEX = 16'sd14189;
  localparam logic signed [COEF_W-1:0] Q_ZERO = 16'sd0;

  // Roll, pitch and yaw weights of one motor
  typedef struct packed {
    logic signed [COEF_W-1:0] roll;
    logic signed [COEF_W-1:0] pitch;
    logic signed [COEF_W-1:0] yaw;
  } coef_set_t;

  // Mixing weights of one motor on one frame; unused motors get zero weights.
  function automatic coef_set_t mix_coef(input logic [1:0] frame,
                                         input logic [MOTOR_W-1:0] motor);
    coef_set_t c;
    c = '{Q_ZERO, Q_ZERO, Q_ZERO};
    case (frame)
      FRAME_TRI: begin
        case (motor)
          3'd0:    c = '{Q_ONE, -Q_2_3, Q_ZERO};
          3'd1:    c = '{-Q_ONE, -Q_2_3, Q_ZERO};
          3'd2:    c = '{Q_ZERO, Q_4_3, Q_ZERO};
          default: c = '{Q_ZERO, Q_ZERO, Q_ZERO};
        endcase
      end
      FRAME_QUAD_X: begin
        case (motor)
          3'd0:    c = '{Q_ONE, -Q_ONE, -Q_ONE};
          3'd1:    c = '{-Q_ONE, -Q_ONE, Q_ONE};
          3'd2:    c = '{-Q_ONE, Q_ONE, -Q_ONE};
          3'd3:    c = '{Q_ONE, Q_ONE, Q_ONE};
          default: c = '{Q_ZERO, Q_ZERO, Q_ZERO};
        endcase
      end
      FRAME_HEX_X: begin
        case (motor)
          3'd0:    c = '{Q_HEX, -Q_ONE, -Q_ONE};
          3'd1:    c = '{-Q_HEX, -Q_ONE, Q_ONE};
          3'd2:    c = '{-Q_HEX, Q_ZERO, -Q_ONE};
          3'd3:    c = '{-Q_HEX, Q_ONE, Q_ONE};
          3'd4:    c = '{Q_HEX, Q_ONE, -Q_ONE};
          3'd5:    c = '{Q_HEX, Q_ZERO, Q_ONE};
          default: c = '{Q_ZERO, Q_ZERO, Q_ZERO};
        endcase
      end
      default: c = '{Q_ZERO, Q_ZERO, Q_ZERO};
    endcase
    return c;
  endfunction

  // Whether a motor is driven on the given frame
  function automatic logic motor_active(input logic [1:0] frame,
                                        input logic [MOTOR_W-1:0] motor);
    logic act;
    case (frame)
      FRAME_TRI:    act = (motor < 3'd3);
      FRAME_QUAD_X: act = (motor < 3'd4);
      FRAME_HEX_X:  act = (motor < 3'd6);
      default:      act = 1'b0;
    endcase
    return act;
  endfunction

endpackage

### rtl/core/multirotor_motor_mixer_core.sv
// Multirotor motor mixer core: tricopter, quad X and hexacopter X frames.
// Depends on mmix_pkg for register indexes, frame codes and coefficients.
//
// A request is taken at every clock edge where start is high; busy is always
// low, so one request per clock is sustained. The work runs through a
// four-register pipeline (input register, motor sums, largest motor, limits
// and overrides), and the six motor commands appear with done high for one
// cycle once the request has passed through all four registers. The
// receiver cannot stall the block, so each result must be captured in its
// one cycle. Configuration is written through wr_en, wr_index and wr_data and
// must only change while no request is in the pipeline.
module multirotor_motor_mixer_core #(
  parameter int DISARMED_COMMAND = 2000
) (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              start,
  output logic                              busy,
  input  logic [mmix_pkg::CMD_W-1:0]        throttle_in,
  input  logic signed [mmix_pkg::CMD_W-1:0] roll_corr,
  input  logic signed [mmix_pkg::CMD_W-1:0] pitch_corr,
  input  logic signed [mmix_pkg::CMD_W-1:0] yaw_corr,
  input  logic [mmix_pkg::CMD_W-1:0]        stick_throttle,
  input  logic                              manual_throttle,
  input  logic                              is_armed,
  // configuration port
  input  logic                              wr_en,
  input  logic [mmix_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [mmix_pkg::CMD_W-1:0]        wr_data,
  // result side
  output logic                              done,
  output logic [mmix_pkg::CMD_W-1:0]        motor_a,
  output logic [mmix_pkg::CMD_W-1:0]        motor_b,
  output logic [mmix_pkg::CMD_W-1:0]        motor_c,
  output logic [mmix_pkg::CMD_W-1:0]        motor_d,
  output logic [mmix_pkg::CMD_W-1:0]        motor_e,
  output logic [mmix_pkg::CMD_W-1:0]        motor_f
);
  import mmix_pkg::*;

  // Width of a full-precision motor sum and of a truncated motor value
  localparam int SUM_W = 32;
  localparam int M_W   = SUM_W - FRAC_W;
  // Width used for the excess correction and clamping
  localparam int ADJ_W = M_W + 2;
  // Width of the servo sum
  localparam int SRV_W = CMD_W + 3;
  localparam logic [CMD_W-1:0] DISARMED = CMD_W'(DISARMED_COMMAND);

  // Configuration registers
  logic [1:0]       frame_type;
  logic             yaw_reverse;
  logic [CMD_W-1:0] min_throttle;
  logic [CMD_W-1:0] max_throttle;
  logic [CMD_W-1:0] stick_low_check;
  logic [CMD_W-1:0] servo_center;
  logic [CMD_W-1:0] servo_low_limit;
  logic [CMD_W-1:0] servo_high_limit;

  // Input register
  logic                    valid_a;
  logic [CMD_W-1:0]        thr_a;
  logic signed [CMD_W-1:0] roll_a;
  logic signed [CMD_W-1:0] pitch_a;
  logic signed [CMD_W-1:0] yaw_a;
  logic [CMD_W-1:0]        stick_a;
  logic                    manual_a;
  logic                    armed_a;

  // Motor sum stage
  logic                  valid_b;
  logic signed [M_W-1:0] m_b [N_MOTORS];
  logic [CMD_W-1:0]      servo_b;
  logic                  low_b;
  logic                  armed_b;
  logic signed [M_W-1:0] m_b_next [N_MOTORS];
  logic [CMD_W-1:0]      servo_b_next;

  // Largest motor stage
  logic                  valid_c;
  logic signed [M_W-1:0] m_c [N_MOTORS];
  logic signed [M_W-1:0] maxm_c;
  logic [CMD_W-1:0]      servo_c;
  logic                  low_c;
  logic                  armed_c;
  logic signed [M_W-1:0] maxm_c_next;

  // Output stage
  logic [CMD_W-1:0] motor_next [N_MOTORS];

  // Every request is taken at once
  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type       <= FRAME_QUAD_X;
      yaw_reverse      <= 1'b0;
      min_throttle     <= 13'd2200;
      max_throttle     <= 13'd4000;
      stick_low_check  <= 13'd2200;
      servo_center     <= 13'd3000;
      servo_low_limit  <= 13'd2000;
      servo_high_limit <= 13'd4000;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_TYPE:       frame_type       <= wr_data[1:0];
        REG_YAW_REVERSE:      yaw_reverse      <= wr_data[0];
        REG_MIN_THROTTLE:     min_throttle     <= wr_data;
        REG_MAX_THROTTLE:     max_throttle     <= wr_data;
        REG_STICK_LOW_CHECK:  stick_low_check  <= wr_data;
        REG_SERVO_CENTER:     servo_center     <= wr_data;
        REG_SERVO_LOW_LIMIT:  servo_low_limit  <= wr_data;
        REG_SERVO_HIGH_LIMIT: servo_high_limit <= wr_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_a <= start & ~busy;
      valid_b <= valid_a;
      valid_c <= valid_b;
      done    <= valid_c;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      thr_a    <= throttle_in;
      roll_a   <= roll_corr;
      pitch_a  <= pitch_corr;
      yaw_a    <= yaw_corr;
      stick_a  <= stick_throttle;
      manual_a <= manual_throttle;
      armed_a  <= is_armed;
    end
  end

  // Motor sums in Q18.14, truncated toward zero, and the tricopter servo
  always_comb begin
    logic signed [CMD_W:0]         yaw_eff;
    logic signed [FRAC_W+CMD_W:0]  thr_q;
    logic signed [CMD_W+COEF_W-1:0] prod_r;
    logic signed [CMD_W+COEF_W-1:0] prod_p;
    logic signed [CMD_W+COEF_W:0]  prod_y;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SRV_W-1:0]       srv;
    coef_set_t                     cs;
    yaw_eff = yaw_reverse ? -(CMD_W+1)'(yaw_a) : (CMD_W+1)'(yaw_a);
    thr_q   = $signed({1'b0, thr_a, {FRAC_W{1'b0}}});
    for (int i = 0; i < N_MOTORS; i++) begin
      cs     = mix_coef(frame_type, MOTOR_W'(i));
      prod_r = roll_a * cs.roll;
      prod_p = pitch_a * cs.pitch;
      prod_y = yaw_eff * cs.yaw;
      sum    = SUM_W'(thr_q) + SUM_W'(prod_r) + SUM_W'(prod_p) + SUM_W'(prod_y);
      // Arithmetic shift floors; a negative sum with a fraction goes up by one
      m_b_next[i] = $signed(sum[SUM_W-1:FRAC_W])
                  + ((sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0)) ? M_W'(1) : M_W'(0));
    end
    srv = $signed({3'b000, servo_center}) + SRV_W'(yaw_eff);
    if (srv < $signed({3'b000, servo_low_limit})) begin
      servo_b_next = servo_low_limit;
    end else if (srv > $signed({3'b000, servo_high_limit})) begin
      servo_b_next = servo_high_limit;
    end else begin
      servo_b_next = srv[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m_b     <= m_b_next;
    servo_b <= servo_b_next;
    low_b   <= (stick_a < stick_low_check) && manual_a;
    armed_b <= armed_a;
  end

  // Largest of the driven motors; motor 0 is driven on every defined frame
  always_comb begin
    maxm_c_next = m_b[0];
    for (int i = 1; i < N_MOTORS; i++) begin
      if (motor_active(frame_type, MOTOR_W'(i)) && (m_b[i] > maxm_c_next)) begin
        maxm_c_next = m_b[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    m_c     <= m_b;
    maxm_c  <= maxm_c_next;
    servo_c <= servo_b;
    low_c   <= low_b;
    armed_c <= armed_b;
  end

  // Excess removal, throttle clamp, stick and arm overrides, undriven motors
  always_comb begin
    logic signed [ADJ_W-1:0] excess;
    logic signed [ADJ_W-1:0] adj;
    logic signed [ADJ_W-1:0] lo;
    logic signed [ADJ_W-1:0] hi;
    lo     = $signed({{(ADJ_W-CMD_W){1'b0}}, min_throttle});
    hi     = $signed({{(ADJ_W-CMD_W){1'b0}}, max_throttle});
    excess = ADJ_W'(maxm_c) - hi;
    for (int i = 0; i < N_MOTORS; i++) begin
      adj = ADJ_W'(m_c[i]);
      if (excess > 0) begin
        adj = adj - excess;
      end
      if (adj < lo) begin
        motor_next[i] = min_throttle;
      end else if (adj > hi) begin
        motor_next[i] = max_throttle;
      end else begin
        motor_next[i] = adj[CMD_W-1:0];
      end
      if (low_c) begin
        motor_next[i] = min_throttle;
      end
      if (!armed_c) begin
        motor_next[i] = DISARMED;
      end
      if (!motor_active(frame_type, MOTOR_W'(i))) begin
        motor_next[i] = '0;
      end
    end
    // The sixth output carries the yaw servo on a tricopter
    if (frame_type == FRAME_TRI) begin
      motor_next[N_MOTORS-1] = servo_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    motor_a <= motor_next[0];
    motor_b <= motor_next[1];
    motor_c <= motor_next[2];
    motor_d <= motor_next[3];
    motor_e <= motor_next[4];
    motor_f <= motor_next[5];
  end

endmodule
